// File: hw/rtl/bsa_pkg.sv
`timescale 1ns / 1ps

package bsa_pkg;

    // Bits of one bitmap word and width of the slot number
    localparam int WORD_BITS  = 8;
    localparam int SLOT_W     = 8;
    localparam int COUNT_W    = 9;
    localparam int CMD_W      = 3;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_MARK_USED = 3'd0,
        CMD_MARK_FREE = 3'd1,
        CMD_TEST      = 3'd2,
        CMD_ALLOC     = 3'd3,
        CMD_CLEAR     = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

endpackage

// File: hw/rtl/bitmap_slot_allocator.sv
`timescale 1ns / 1ps

// Bitmap slot allocator: a used/free bitmap of min(ENTRIES, 256) slots, kept
// in a small synchronous RAM of 8-bit words, and a count of successful allocates.
// Input channel (s_axis): one command item = cmd and slot. Output channel
// (m_axis): one result item per command = ok, slot_out, is_used, used_count.
// Commands: mark used, mark free, test, allocate lowest free slot (slot 0 is
// never handed out), clear all.
// Sequence: mark, test, clear and any rejected command go straight to the final
// step. Allocate reads one bitmap word per cycle from word 0 until it finds a
// clear bit or has read the last word, then takes the final step. The RAM read
// port sets the pace of the scan. One command is in work at a time; the next item
// is accepted as soon as the previous result has moved into the output register.
// Reset: every word is marked invalid (reads as all free) and the count is
// zeroed; the RAM contents themselves are not swept. Clear all does the same.
// Stall: when m_axis_tready is low the result holds in the output register;
// the block may accept and work one more command, then holds it in the final
// step until the output register frees.
module bitmap_slot_allocator #(
    parameter int ENTRIES = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [2:0] cmd, [10:3] slot, [15:11] zero
    input  logic [bsa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] ok, [8:1] slot_out, [9] is_used, [18:10] used_count, [23:19] zero
    output logic [bsa_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import bsa_pkg::*;

    localparam int SLOTS     = (ENTRIES < 256) ? ENTRIES : 256;
    localparam int MAP_WORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WW        = $clog2(MAP_WORDS);
    // Counts reach at most 511, so a larger ENTRIES never blocks allocation
    localparam int LIMIT     = (ENTRIES > 511) ? 512 : ENTRIES;
    localparam logic [WW-1:0] LAST_W = WW'(MAP_WORDS - 1);

    // Bitmap RAM and per-word valid bits (invalid word reads as all free)
    logic [WORD_BITS-1:0] r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_vld;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rvld;

    t_state               r_state, n_state;
    t_cmd                 r_cmd;
    logic [SLOT_W-1:0]    r_slot;
    logic                 r_inside;
    logic                 r_found, n_found;
    logic [WW-1:0]        r_widx, n_widx;
    logic [COUNT_W-1:0]   r_count, n_count;

    logic                 r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata, n_odata;

    // RAM control
    logic                 rd_en;
    logic [WW-1:0]        rd_addr;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic                 clr_all;

    // Decode of the incoming item
    logic                 s_acc;
    t_cmd                 in_cmd;
    logic [SLOT_W-1:0]    in_slot;
    logic                 in_inside;
    logic                 cnt_room;

    // Word under inspection
    logic [WORD_BITS-1:0] word_eff;
    logic [WORD_BITS-1:0] avail;
    logic                 hit;
    logic [2:0]           hit_pos;
    logic                 out_free;

    logic                 res_ok;
    logic [SLOT_W-1:0]    res_slot;
    logic                 res_used;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = t_cmd'(s_axis_tdata[CMD_W-1:0]);
    assign in_slot       = s_axis_tdata[CMD_W +: SLOT_W];
    assign in_inside     = {1'b0, in_slot} < 9'(SLOTS);
    assign cnt_room      = {1'b0, r_count} < 10'(LIMIT);
    assign out_free      = !r_ovalid || m_axis_tready;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign word_eff = r_rvld ? r_rdata : '0;

    // Free bits of the current word, excluding slot 0 and slots past the map
    always_comb begin
        logic [8:0] sl;
        for (int b = 0; b < WORD_BITS; b++) begin
            sl       = 9'({r_widx, 3'(b)});
            avail[b] = !word_eff[b] && (sl != 9'd0) && (sl < 9'(SLOTS));
        end
    end

    // Lowest free bit
    always_comb begin
        hit_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (avail[b]) begin
                hit_pos = 3'(b);
            end
        end
    end
    assign hit = |avail;

    // Sequencer: next state, RAM control and result
    always_comb begin
        n_state  = r_state;
        n_found  = r_found;
        n_widx   = r_widx;
        n_count  = r_count;
        n_odata  = r_odata;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_data  = word_eff;
        clr_all  = 1'b0;
        res_ok   = 1'b0;
        res_slot = '0;
        res_used = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_found = 1'b0;
                    n_state = ST_FIN;
                    unique case (in_cmd) inside
                        CMD_MARK_USED, CMD_MARK_FREE, CMD_TEST: begin
                            if (in_inside) begin
                                rd_en   = 1'b1;
                                rd_addr = in_slot[WW+2:3];
                                n_widx  = in_slot[WW+2:3];
                            end
                        end
                        CMD_ALLOC: begin
                            // scan from word 0 only while the count has room
                            if (cnt_room) begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_widx  = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN: begin
                if (hit) begin
                    // hold r_rdata; the final step sets the bit
                    n_found = 1'b1;
                    n_state = ST_FIN;
                end else if (r_widx == LAST_W) begin
                    n_state = ST_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_widx + 1'b1;
                    n_widx  = r_widx + 1'b1;
                end
            end

            ST_FIN: begin
                unique case (r_cmd)
                    CMD_MARK_USED: begin
                        res_ok  = r_inside;
                        wr_en   = r_inside;
                        wr_data = word_eff | (8'd1 << r_slot[2:0]);
                    end
                    CMD_MARK_FREE: begin
                        res_ok  = r_inside;
                        wr_en   = r_inside;
                        wr_data = word_eff & ~(8'd1 << r_slot[2:0]);
                    end
                    CMD_TEST: begin
                        res_ok   = r_inside;
                        res_used = r_inside && word_eff[r_slot[2:0]];
                    end
                    CMD_ALLOC: begin
                        res_ok   = r_found;
                        wr_en    = r_found;
                        wr_data  = word_eff | (8'd1 << hit_pos);
                        res_slot = r_found ? SLOT_W'({r_widx, hit_pos}) : '0;
                    end
                    CMD_CLEAR: begin
                        res_ok  = 1'b1;
                        clr_all = 1'b1;
                    end
                    default: ;
                endcase

                if (out_free) begin
                    if (clr_all) begin
                        n_count = '0;
                    end else if (r_cmd == CMD_ALLOC && r_found) begin
                        n_count = r_count + 1'b1;
                    end
                    n_odata = OUT_DATA_W'({n_count, res_used, res_slot, res_ok});
                    n_state = ST_IDLE;
                end else begin
                    // hold until the output register frees
                    wr_en   = 1'b0;
                    clr_all = 1'b0;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // Bitmap RAM: one read and one write port, registered read data
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_widx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rvld <= r_vld[rd_addr];
            end
            if (clr_all) begin
                r_vld <= '0;
            end else if (wr_en) begin
                r_vld[r_widx] <= 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_found <= n_found;
            if (r_state == ST_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_widx  <= n_widx;
        r_odata <= n_odata;
        if (s_acc) begin
            r_cmd    <= in_cmd;
            r_slot   <= in_slot;
            r_inside <= in_inside;
        end
    end

endmodule

// File: hw/rtl/bsa_checker.sv
`timescale 1ns / 1ps

module bsa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [bsa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [bsa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import bsa_pkg::*;

    logic             ok;
    logic [7:0]       slot_out;
    logic             is_used;

    assign ok       = m_axis_tdata[0];
    assign slot_out = m_axis_tdata[8:1];
    assign is_used  = m_axis_tdata[9];

    // Output register comes out of reset empty
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A failed command never reports a slot
    a_fail_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !ok |-> slot_out == 8'd0 && !is_used)
        else $error("failed command carries slot or used flag");

    // Allocation results never carry a test bit
    a_alloc_no_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && slot_out != 8'd0 |-> ok && !is_used)
        else $error("allocated slot with bad flags");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);
